[rtl/core/gci_pkg.sv]
package gci_pkg;
    localparam int MaxPoints = 6;
    localparam int PtW = 41;
    localparam int PosW = 17;
    localparam logic [PosW-1:0] PosMax = 17'h1FFFF;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 41;
    localparam int QDepth = 2;

    localparam logic [CfgIdxW-1:0] RegStripLength = 3'd0;
    localparam logic [CfgIdxW-1:0] RegPointCount = 3'd1;
    localparam logic [CfgIdxW-1:0] RegPoint0 = 3'd2;

    typedef struct packed {
        logic [PosW-1:0] pos;
    } t_job;
endpackage

[rtl/core/gci_if.sv]
interface gci_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] line_index;
    modport source (output valid, output line_index, input ready);
    modport sink (input valid, input line_index, output ready);
endinterface

interface gci_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface gci_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [gci_pkg::CfgIdxW-1:0]   index;
    logic [gci_pkg::CfgDataW-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/gradient_color_interpolator_top.sv]
// Piecewise linear color gradient. Each line_index request yields one RGB result.
// The front unit divides line_index by strip_length with a bit-serial divider
// and queues the Q1.16 position; the back unit scans up to six points (one per
// cycle), runs a second division for the blend fraction and blends the three
// channels in turn. A position before the first point or at or past the last
// takes that end point's color with no division or blend; a zero strip_length
// skips the front division. The two halves overlap through a two-entry queue.
// Configuration writes are taken at any time and must be made while idle.
module gradient_color_interpolator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gci_in_if.sink     in_ch,
    gci_out_if.source  out_ch,
    gci_cfg_if.sink    cfg_ch
);
    logic [12:0]               r_strip_length;
    logic [2:0]                r_point_count;
    logic [gci_pkg::PtW-1:0]   r_points [gci_pkg::MaxPoints];
    logic                      w_push, w_full, w_pop, w_empty;
    gci_pkg::t_job             w_job_in, w_job_out;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_length <= 13'd256;
            r_point_count  <= 3'd1;
            for (int k = 0; k < gci_pkg::MaxPoints; k++) r_points[k] <= '0;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                gci_pkg::RegStripLength: r_strip_length <= cfg_ch.data[12:0];
                gci_pkg::RegPointCount:  r_point_count  <= cfg_ch.data[2:0];
                default: begin
                    if (cfg_ch.index >= gci_pkg::RegPoint0)
                        r_points[cfg_ch.index - gci_pkg::RegPoint0] <= cfg_ch.data;
                end
            endcase
        end
    end

    gci_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .i_strip_length(r_strip_length),
        .o_push(w_push), .o_job(w_job_in), .i_full(w_full)
    );

    gci_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_job(w_job_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_job(w_job_out)
    );

    gci_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(w_empty), .i_job(w_job_out), .o_pop(w_pop),
        .i_point_count(r_point_count), .i_points(r_points),
        .out_ch(out_ch)
    );
endmodule

[rtl/core/gci_div.sv]
// Restoring divider: quotient of num / den, one bit per cycle.
module gci_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [32:0] o_quot
);
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] r_q;
    logic [17:0] r_rem;
    logic [16:0] r_den;
    logic [17:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem[16:0], r_q[32]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
                r_q   <= {r_q[31:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule

[rtl/core/gci_front.sv]
// Front: compute the Q1.16 position of each request and push it into the queue.
module gci_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gci_in_if.sink                in_ch,
    input  logic [12:0]           i_strip_length,
    output logic                  o_push,
    output gci_pkg::t_job         o_job,
    input  logic                  i_full
);
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;
    t_state        r_state;
    logic          w_done;
    logic [32:0]   w_quot;
    logic          w_start;
    gci_pkg::t_job r_job;

    assign in_ch.ready = (r_state == S_IDLE);
    assign w_start = in_ch.valid && in_ch.ready && (i_strip_length != 13'd0);

    gci_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num({5'd0, in_ch.line_index, 16'd0}),
        .i_den({4'd0, i_strip_length}),
        .o_done(w_done), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        if (i_strip_length == 13'd0) begin
                            r_job.pos <= gci_pkg::PosMax;
                            r_state   <= S_PUSH;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        r_job.pos <= (w_quot > {16'd0, gci_pkg::PosMax}) ?
                                     gci_pkg::PosMax : w_quot[16:0];
                        r_state   <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_job  = r_job;
endmodule

[rtl/core/gci_queue.sv]
module gci_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gci_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output gci_pkg::t_job o_job
);
    gci_pkg::t_job r_mem [gci_pkg::QDepth];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

[rtl/core/gci_back.sv]
// Back: scan control points, divide for t, blend channels one per cycle.
module gci_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  gci_pkg::t_job                  i_job,
    output logic                           o_pop,
    input  logic [2:0]                     i_point_count,
    input  logic [gci_pkg::PtW-1:0]        i_points [gci_pkg::MaxPoints],
    gci_out_if.source                      out_ch
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_MIX, S_OUT} t_state;
    t_state      r_state;
    logic [16:0] r_pos;
    logic [2:0]  r_k, r_n;
    logic [16:0] r_t;
    logic [1:0]  r_ch;
    logic [7:0]  r_rgb [3];
    logic        w_start, w_done;
    logic [32:0] w_quot;
    logic [2:0]  w_n;
    logic [2:0]  w_a;
    logic [16:0] w_pk, w_pa;
    logic [7:0]  w_ca, w_cb;
    logic [25:0] w_v;

    assign w_n = (i_point_count == 3'd0) ? 3'd1 :
                 (i_point_count > 3'(gci_pkg::MaxPoints)) ? 3'(gci_pkg::MaxPoints) :
                 i_point_count;
    assign w_pk = i_points[r_k][40:24];
    assign w_a  = r_k - 3'd1;
    assign w_pa = i_points[w_a][40:24];
    assign w_start = (r_state == S_SCAN) && (r_k != 3'd0) && (r_k != r_n)
                     && (r_pos < w_pk);

    gci_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num({r_pos - w_pa, 16'd0}),
        .i_den(w_pk - w_pa),
        .o_done(w_done), .o_quot(w_quot)
    );

    always_comb begin
        w_ca = i_points[w_a][8*(2-r_ch) +: 8];
        w_cb = i_points[r_k][8*(2-r_ch) +: 8];
    end
    assign w_v = {2'b0, w_ca, 16'd0} - (26'(w_ca) * 26'(r_t))
                 + (26'(w_cb) * 26'(r_t)) + 26'd32768;

    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.red   = r_rgb[0];
    assign out_ch.green = r_rgb[1];
    assign out_ch.blue  = r_rgb[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_pos   <= i_job.pos;
                        r_n     <= w_n;
                        r_k     <= 3'd0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_k != r_n && r_pos >= w_pk) begin
                        r_k <= r_k + 3'd1;
                    end else if (r_k == 3'd0 || r_k == r_n) begin
                        r_rgb[0] <= i_points[(r_k == 3'd0) ? 3'd0 : w_a][23:16];
                        r_rgb[1] <= i_points[(r_k == 3'd0) ? 3'd0 : w_a][15:8];
                        r_rgb[2] <= i_points[(r_k == 3'd0) ? 3'd0 : w_a][7:0];
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        r_t     <= (w_quot > 33'hFFFF) ? 17'hFFFF : w_quot[16:0];
                        r_ch    <= 2'd0;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_rgb[r_ch] <= w_v[23:16];
                    r_ch <= r_ch + 2'd1;
                    if (r_ch == 2'd2) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_ch.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[test/tb_top.sv]
module tb_top;
    localparam int LatencyCycles = 120;
    localparam int CycleLimit = 900000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    class color_scoreboard;
        logic [12:0]   strip_len;
        logic [2:0]    pt_count;
        logic [gci_pkg::PtW-1:0] pts[gci_pkg::MaxPoints];
        t_color        pending[$];
        int            errors;

        function void reset_regs();
            strip_len = 13'd256;
            pt_count = 3'd1;
            foreach (pts[k]) pts[k] = '0;
        endfunction

        function void write_reg(logic [gci_pkg::CfgIdxW-1:0] idx,
                                logic [gci_pkg::CfgDataW-1:0] val);
            if (idx == gci_pkg::RegStripLength) strip_len = val[12:0];
            else if (idx == gci_pkg::RegPointCount) pt_count = val[2:0];
            else if (idx - gci_pkg::RegPoint0 < gci_pkg::MaxPoints)
                pts[idx - gci_pkg::RegPoint0] = val;
        endfunction

        function t_color sample_color(logic [11:0] line);
            logic [63:0] q, num, den, t, v;
            logic [gci_pkg::PosW-1:0] pos, pa, pb;
            int n, k;
            t_color c;
            if (strip_len == 0) pos = gci_pkg::PosMax;
            else begin
                q = {36'd0, line, 16'd0} / strip_len;
                pos = (q > gci_pkg::PosMax) ? gci_pkg::PosMax : q[gci_pkg::PosW-1:0];
            end
            n = pt_count;
            if (n == 0) n = 1;
            if (n > gci_pkg::MaxPoints) n = gci_pkg::MaxPoints;
            k = 0;
            while (k < n && pos >= pts[k][40:24]) k++;
            if (k == 0 || k == n) begin
                c = pts[(k == 0) ? 0 : k - 1][23:0];
                return c;
            end
            pa = pts[k-1][40:24];
            pb = pts[k][40:24];
            num = 64'(pos - pa) << 16;
            den = 64'(pb - pa);
            t = num / den;
            if (t > 64'hFFFF) t = 64'hFFFF;
            for (int ch = 0; ch < 3; ch++) begin
                v = 64'(pts[k-1][ch*8 +: 8]) * (65536 - t) + 64'(pts[k][ch*8 +: 8]) * t
                    + 32768;
                c[ch*8 +: 8] = v[23:16];
            end
            return c;
        endfunction

        function void note_line(logic [11:0] line);
            pending.push_back(sample_color(line));
        endfunction

        task check_color(t_color got);
            t_color want;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending", 0, got);
                return;
            end
            want = pending.pop_front();
            if (got.red !== want.red) report_mismatch("red", want.red, got.red);
            if (got.green !== want.green) report_mismatch("green", want.green, got.green);
            if (got.blue !== want.blue) report_mismatch("blue", want.blue, got.blue);
        endtask

        task report_mismatch(string what, logic [23:0] want, logic [23:0] got);
            errors++;
            if (errors <= 40) $display("mismatch %s: want %0h got %0h", what, want, got);
        endtask
    endclass

    logic i_clk, i_rst_n;
    gci_in_if  in_ch();
    gci_out_if out_ch();
    gci_cfg_if cfg_ch();

    gradient_color_interpolator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
    );

    color_scoreboard sb;
    int cycles;
    bit hold_sink;
    bit sink_random;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // check accepted results; ready stays high unless hold or random back-pressure is on
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_color({out_ch.red, out_ch.green, out_ch.blue});
    end

    initial begin
        int g;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) out_ch.ready <= 1'b0;
            else if (!sink_random) out_ch.ready <= 1'b1;
            else begin
                g = gap_len();
                if (g == 0) out_ch.ready <= 1'b1;
                else begin
                    out_ch.ready <= 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    task automatic write_cfg(logic [gci_pkg::CfgIdxW-1:0] idx,
                             logic [gci_pkg::CfgDataW-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // valid stays up after a request; a gap or drain() drops it
    task automatic send_line(logic [11:0] line, bit idle);
        int g;
        g = idle ? gap_len() : 0;
        if (g != 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.line_index <= line;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_line(line);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LatencyCycles) @(posedge i_clk);
    endtask

    // mostly sorted random points, occasional duplicates, an unsorted setting
    task automatic load_points(int mode);
        logic [gci_pkg::PosW-1:0] p;
        logic [gci_pkg::CfgDataW-1:0] w;
        p = $urandom_range(0, 8000);
        for (int k = 0; k < gci_pkg::MaxPoints; k++) begin
            w = {$urandom(), $urandom()};
            if (mode == 1) w[40:24] = $urandom();
            else begin
                w[40:24] = p;
                if ($urandom_range(0, 5) != 0) p = p + $urandom_range(1, 30000);
                if (p > 17'h1C000) p = 17'h1FFFF;
            end
            write_cfg(gci_pkg::RegPoint0 + k, w);
        end
    endtask

    initial begin
        logic [12:0] lens[6];
        int lmax;
        sb = new();
        sb.reset_regs();
        hold_sink = 0;
        sink_random = 0;
        in_ch.valid = 1'b0;
        in_ch.line_index = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults, then directed extremes
        send_line(12'd0, 0);
        send_line(12'hFFF, 0);
        drain();
        write_cfg(gci_pkg::RegPoint0, {17'd0, 24'hFF0000});
        write_cfg(gci_pkg::RegPoint0 + 1, {17'h08000, 24'h00FF80});
        write_cfg(gci_pkg::RegPoint0 + 2, {17'h10000, 24'hFFFFFF});
        write_cfg(gci_pkg::RegPoint0 + 3, {17'h1FFFF, 24'h000000});
        write_cfg(gci_pkg::RegPoint0 + 4, {17'h1FFFF, 24'h123456});
        write_cfg(gci_pkg::RegPoint0 + 5, {17'h1FFFF, 24'hABCDEF});
        write_cfg(gci_pkg::RegPointCount, 3'd4);
        write_cfg(gci_pkg::RegStripLength, 13'd4096);
        foreach (lens[i]) lens[i] = 0;
        for (int l = 0; l < 4096; l += 512) send_line(l[11:0], 0);
        send_line(12'hFFF, 0);
        send_line(12'd2048, 0);
        drain();
        write_cfg(gci_pkg::RegStripLength, 13'd0);   // zero length saturates
        send_line(12'd5, 0);
        drain();
        write_cfg(gci_pkg::RegStripLength, 13'd1);   // length one; lines sent stay in range
        write_cfg(gci_pkg::RegPointCount, 3'd0);
        send_line(12'd1, 0);
        send_line(12'd0, 0);
        drain();
        write_cfg(gci_pkg::RegPointCount, 3'd7);
        write_cfg(gci_pkg::RegStripLength, 13'h1FFF);
        send_line(12'hFFF, 0);
        send_line(12'd100, 0);
        drain();
        write_cfg(3'd7 + 3'd1, 41'd0);      // wraps to strip length
        write_cfg(gci_pkg::RegStripLength, 13'd3000);

        // random phases
        lens = '{13'd1, 13'd4096, 13'd8191, 13'd256, 13'd3000, 13'd0};
        sink_random = 1;
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            if ($urandom_range(0, 2) == 0)
                write_cfg(gci_pkg::RegStripLength, lens[$urandom_range(0, 5)]);
            else write_cfg(gci_pkg::RegStripLength, $urandom_range(1, 8191));
            write_cfg(gci_pkg::RegPointCount, $urandom_range(0, 7));
            load_points((ph == 7) ? 1 : 0);
            lmax = (sb.strip_len > 4095 || sb.strip_len == 0) ? 4095 : 2 * sb.strip_len;
            if (lmax > 4095) lmax = 4095;
            if (ph == 3) begin
                hold_sink = 1;
                fork
                    begin
                        repeat (400) @(posedge i_clk);
                        hold_sink = 0;
                    end
                join_none
            end
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 9) == 0) send_line($urandom(), 1);
                else send_line($urandom_range(0, lmax), 1);
            end
            if (ph == 5) drain();
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
